// ===== rtl/core/ibf_pkg.sv =====
// ----------------------------------------------------------------------------
// ibf_pkg
// Shared types and constants for the IR beacon burst angle finder.
// ----------------------------------------------------------------------------
package ibf_pkg;

  localparam int NUM_BEACONS = 3;
  localparam int ANGLE_SHIFT = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] GAP_RESET   = 16'd30;
  localparam logic [15:0] TURN_RESET  = 16'd2353;
  localparam logic [15:0] SCALE_RESET = 16'd223;

  // item kinds
  localparam logic ACT_EDGE    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  // beacon codes
  localparam logic [1:0] BEACON_MOTHER = 2'd0;
  localparam logic [1:0] BEACON_CORNER = 2'd1;
  localparam logic [1:0] BEACON_MIDDLE = 2'd2;
  localparam logic [1:0] BEACON_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_GAP   = 2'd0;
  localparam logic [1:0] REG_TURN  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_CORNER_MID = 2'd1;
  localparam logic [1:0] STATUS_MID_MOTHER = 2'd2;
  localparam logic [1:0] STATUS_MOTHER_COR = 2'd3;

  typedef struct packed {
    logic        action;
    logic [1:0]  beacon;
    logic [15:0] timestamp;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_req_t;

endpackage

// ===== rtl/core/ibf_front.sv =====
// ----------------------------------------------------------------------------
// ibf_front
// Input stage: accepts requests, drops edges of unknown beacons, and hands
// classified items to the queue.
// ----------------------------------------------------------------------------
module ibf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_action,
  input  logic [1:0]     in_beacon,
  input  logic [15:0]    in_timestamp,
  input  logic           q_full,
  output ibf_pkg::q_req_t push
);

  logic           valid_r, valid_nxt;
  ibf_pkg::item_t item_r, item_nxt;
  logic           push_fire;
  logic           accept;
  logic           keep;

  assign push_fire = valid_r && !q_full;
  assign in_ready  = !valid_r || push_fire;
  assign accept    = in_valid && in_ready;
  // drop edges tagged with the unused beacon code
  assign keep      = (in_action == ibf_pkg::ACT_COMPUTE) ||
                     (in_beacon != ibf_pkg::BEACON_NONE);

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (push_fire) begin
      valid_nxt = 1'b0;
    end
    if (accept && keep) begin
      valid_nxt          = 1'b1;
      item_nxt.action    = in_action;
      item_nxt.beacon    = in_beacon;
      item_nxt.timestamp = in_timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push.valid = push_fire;
  assign push.item  = item_r;

endmodule

// ===== rtl/core/ibf_queue.sv =====
// ----------------------------------------------------------------------------
// ibf_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module ibf_queue #(
  parameter int DEPTH = ibf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ibf_pkg::q_req_t push,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ibf_pkg::item_t  head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ibf_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

// ===== rtl/core/ibf_back.sv =====
// ----------------------------------------------------------------------------
// ibf_back
// Burst trackers per beacon and the end-of-rotation angle sequencer.
// ----------------------------------------------------------------------------
module ibf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               head_valid,
  input  ibf_pkg::item_t     head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_angle_a,
  output logic signed [15:0] out_angle_b,
  output logic [1:0]         out_status
);

  localparam int NB = ibf_pkg::NUM_BEACONS;
  localparam int SH = ibf_pkg::ANGLE_SHIFT;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REBASE = 3'd1;
  localparam logic [2:0] ST_WRAP   = 3'd2;
  localparam logic [2:0] ST_ORDER  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam logic [1:0] BR_MOTHER = 2'd0;
  localparam logic [1:0] BR_CORNER = 2'd1;
  localparam logic [1:0] BR_MIDDLE = 2'd2;

  logic [15:0] gap_r, turn_r, scale_r;

  logic [15:0] bbeg_r [NB];
  logic [15:0] bend_r [NB];
  logic [15:0] blen_r [NB];
  logic [15:0] blong_r [NB];
  logic [15:0] bctr_r [NB];
  logic [15:0] bbeg_nxt [NB];
  logic [15:0] bend_nxt [NB];
  logic [15:0] blen_nxt [NB];
  logic [15:0] blong_nxt [NB];
  logic [15:0] bctr_nxt [NB];
  logic [15:0] final_ctr [NB];

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  br_r, br_nxt;
  logic [15:0] mo_r, co_r, mi_r;
  logic [15:0] x_r, x_nxt, y_r, y_nxt;
  logic [15:0] a_r, a_nxt, b_r, b_nxt;
  logic [1:0]  status_r, status_nxt;
  logic signed [32:0] pa_r, pb_r;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_a_r, out_b_r;
  logic [1:0]  out_status_r;
  logic        out_load;

  logic        pop_edge, pop_comp;
  logic [16:0] diff [NB];
  logic        cont [NB];

  assign pop      = head_valid && (state_r == ST_IDLE);
  assign pop_edge = pop && (head_item.action == ibf_pkg::ACT_EDGE);
  assign pop_comp = pop && (head_item.action == ibf_pkg::ACT_COMPUTE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // burst trackers, one lane per beacon
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      diff[k] = {1'b0, head_item.timestamp} - {1'b0, bend_r[k]};
      cont[k] = $signed(diff[k]) < $signed({1'b0, gap_r});
      final_ctr[k] = (blen_r[k] > blong_r[k]) ?
                     bbeg_r[k] + {1'b0, blen_r[k][15:1]} : bctr_r[k];
      bbeg_nxt[k]  = bbeg_r[k];
      bend_nxt[k]  = bend_r[k];
      blen_nxt[k]  = blen_r[k];
      blong_nxt[k] = blong_r[k];
      bctr_nxt[k]  = bctr_r[k];
      if (pop_edge && head_item.beacon == 2'(k)) begin
        if (cont[k]) begin
          bend_nxt[k] = head_item.timestamp;
          blen_nxt[k] = head_item.timestamp - bbeg_r[k];
        end else begin
          // close the open burst, keep it if it is the longest
          if (blen_r[k] > blong_r[k]) begin
            blong_nxt[k] = blen_r[k];
            bctr_nxt[k]  = final_ctr[k];
          end
          bbeg_nxt[k] = head_item.timestamp;
          bend_nxt[k] = head_item.timestamp;
          blen_nxt[k] = '0;
        end
      end
      if (pop_comp) begin
        bbeg_nxt[k]  = '0;
        bend_nxt[k]  = '0;
        blen_nxt[k]  = '0;
        blong_nxt[k] = '0;
        bctr_nxt[k]  = '0;
      end
    end
  end

  // angle sequencer
  always_comb begin
    state_nxt  = state_r;
    br_nxt     = br_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_comp) begin
          state_nxt = ST_REBASE;
        end
      end
      ST_REBASE: begin
        // rebase to the earliest centre; ties fall to the middle branch
        priority if (mo_r < co_r && mo_r < mi_r) begin
          br_nxt = BR_MOTHER;
          x_nxt  = co_r - mo_r;
          y_nxt  = mi_r - mo_r;
        end else if (co_r < mo_r && co_r < mi_r) begin
          br_nxt = BR_CORNER;
          x_nxt  = mo_r - co_r;
          y_nxt  = mi_r - co_r;
        end else begin
          br_nxt = BR_MIDDLE;
          x_nxt  = mo_r - mi_r;
          y_nxt  = co_r - mi_r;
        end
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        x_nxt     = (x_r > turn_r) ? x_r - turn_r : x_r;
        y_nxt     = (y_r > turn_r) ? y_r - turn_r : y_r;
        state_nxt = ST_ORDER;
      end
      ST_ORDER: begin
        status_nxt = ibf_pkg::STATUS_OK;
        a_nxt      = '0;
        b_nxt      = '0;
        unique case (br_r)
          BR_MOTHER: begin
            if (x_r < y_r) begin
              status_nxt = ibf_pkg::STATUS_CORNER_MID;
            end
            a_nxt = turn_r - x_r;
            b_nxt = y_r;
          end
          BR_CORNER: begin
            if (y_r < x_r) begin
              status_nxt = ibf_pkg::STATUS_MID_MOTHER;
            end
            a_nxt = x_r;
            b_nxt = y_r - x_r;
          end
          default: begin
            if (x_r < y_r) begin
              status_nxt = ibf_pkg::STATUS_MOTHER_COR;
            end
            a_nxt = x_r - y_r;
            b_nxt = turn_r - x_r;
          end
        endcase
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= ibf_pkg::GAP_RESET;
      turn_r      <= ibf_pkg::TURN_RESET;
      scale_r     <= ibf_pkg::SCALE_RESET;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NB; k++) begin
        bbeg_r[k]  <= '0;
        bend_r[k]  <= '0;
        blen_r[k]  <= '0;
        blong_r[k] <= '0;
        bctr_r[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ibf_pkg::REG_GAP:   gap_r   <= cfg_wdata;
          ibf_pkg::REG_TURN:  turn_r  <= cfg_wdata;
          ibf_pkg::REG_SCALE: scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < NB; k++) begin
        bbeg_r[k]  <= bbeg_nxt[k];
        bend_r[k]  <= bend_nxt[k];
        blen_r[k]  <= blen_nxt[k];
        blong_r[k] <= blong_nxt[k];
        bctr_r[k]  <= bctr_nxt[k];
      end
    end
    if (pop_comp) begin
      mo_r <= final_ctr[ibf_pkg::BEACON_MOTHER];
      co_r <= final_ctr[ibf_pkg::BEACON_CORNER];
      mi_r <= final_ctr[ibf_pkg::BEACON_MIDDLE];
    end
    br_r     <= br_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    status_r <= status_nxt;
    pa_r     <= 33'($signed(a_r)) * 33'($signed({1'b0, scale_r}));
    pb_r     <= 33'($signed(b_r)) * 33'($signed({1'b0, scale_r}));
    if (out_load) begin
      // arithmetic shift gives floor rounding; zero the angles on error
      out_status_r <= status_r;
      out_a_r      <= (status_r == ibf_pkg::STATUS_OK) ? pa_r[SH+15:SH] : '0;
      out_b_r      <= (status_r == ibf_pkg::STATUS_OK) ? pb_r[SH+15:SH] : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_angle_a = $signed(out_a_r);
  assign out_angle_b = $signed(out_b_r);
  assign out_status  = out_status_r;

endmodule

// ===== rtl/core/ir_beacon_burst_angle_finder.sv =====
// Path: an end-of-rotation request passes the input register, the queue,
//   and the sequencer states REBASE, WRAP, ORDER, MUL and OUT to out_valid.
// Throughput: one edge request per cycle while the queue has room; an
//   end-of-rotation request holds the back end until its result is loaded.
// Reset: synchronous, active low; clears burst state, queue and output, and
//   loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// ir_beacon_burst_angle_finder
// Tracks IR bursts per beacon and computes beacon angles once per rotation.
// ----------------------------------------------------------------------------
module ir_beacon_burst_angle_finder #(
  parameter int QUEUE_DEPTH = ibf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [1:0]         in_beacon,
  input  logic [15:0]        in_timestamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_angle_a,
  output logic signed [15:0] out_angle_b,
  output logic [1:0]         out_status
);

  ibf_pkg::q_req_t push;
  ibf_pkg::item_t  head_item;
  logic            q_full;
  logic            head_valid;
  logic            pop;

  ibf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_beacon    (in_beacon),
    .in_timestamp (in_timestamp),
    .q_full       (q_full),
    .push         (push)
  );

  ibf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ibf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_angle_a (out_angle_a),
    .out_angle_b (out_angle_b),
    .out_status  (out_status)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives edge and end-of-rotation requests into the burst angle finder.
// Sender bursts and receiver stalls are random, and the register settings
// are stepped through defaults, extremes and random values. Results are
// checked with a local model of burst and angle math or fixed script values.
// ----------------------------------------------------------------------------
module tb;
  import ibf_pkg::*;

  localparam int DRAIN       = 32;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [1:0]         st;
  } angle_t;

  typedef struct packed {
    logic        act;
    logic [1:0]  bc;
    logic [15:0] ts;
    logic        typed;
    angle_t      res;
  } row_t;

  // directed requests, run at the reset settings
  localparam row_t SCRIPT [23] = '{
    '{ACT_COMPUTE, BEACON_NONE,   16'd0,     1'b1, '{16'sd0, 16'sd128, STATUS_OK}},
    '{ACT_EDGE,    BEACON_CORNER, 16'd200,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_CORNER, 16'd210,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MIDDLE, 16'd300,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MIDDLE, 16'd310,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_COMPUTE, BEACON_MOTHER, 16'd0,     1'b1, '{16'sd0, 16'sd0, STATUS_CORNER_MID}},
    '{ACT_EDGE,    BEACON_MOTHER, 16'd300,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MOTHER, 16'd310,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MIDDLE, 16'd200,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MIDDLE, 16'd210,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_COMPUTE, BEACON_CORNER, 16'd0,     1'b1, '{16'sd0, 16'sd0, STATUS_MID_MOTHER}},
    '{ACT_EDGE,    BEACON_MOTHER, 16'd200,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MOTHER, 16'd210,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_CORNER, 16'd300,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_CORNER, 16'd310,   1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_COMPUTE, BEACON_MIDDLE, 16'd0,     1'b1, '{16'sd0, 16'sd0, STATUS_MOTHER_COR}},
    // early first edge joins a burst that starts at zero
    '{ACT_EDGE,    BEACON_MOTHER, 16'd12,    1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_NONE,   16'hFFFF,  1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_CORNER, 16'hFFFF,  1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    // time runs backwards: still the same burst
    '{ACT_EDGE,    BEACON_CORNER, 16'd0,     1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MIDDLE, 16'd40000, 1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_EDGE,    BEACON_MIDDLE, 16'd40020, 1'b0, '{16'sd0, 16'sd0, STATUS_OK}},
    '{ACT_COMPUTE, BEACON_NONE,   16'hFFFF,  1'b0, '{16'sd0, 16'sd0, STATUS_OK}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GAP;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_action = ACT_EDGE;
  logic [1:0]  in_beacon = BEACON_MOTHER;
  logic [15:0] in_timestamp = 16'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic signed [15:0] out_angle_a;
  logic signed [15:0] out_angle_b;
  logic [1:0]  out_status;

  ir_beacon_burst_angle_finder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_beacon    (in_beacon),
    .in_timestamp (in_timestamp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle_a  (out_angle_a),
    .out_angle_b  (out_angle_b),
    .out_status   (out_status)
  );

  always #10 clk = ~clk;

  // model registers and burst trackers
  logic [15:0] gap_limit, turn_ticks, angle_gain;
  logic [15:0] run_start [NUM_BEACONS];
  logic [15:0] run_stop  [NUM_BEACONS];
  logic [15:0] run_len   [NUM_BEACONS];
  logic [15:0] peak_len  [NUM_BEACONS];
  logic [15:0] peak_mid  [NUM_BEACONS];

  angle_t     angles_due [$];
  int         fault_count = 0;
  int         sent = 0;
  int         run_left = 0;
  logic [7:0] rx_phase = 8'd0;

  function automatic void clear_bursts();
    for (int k = 0; k < NUM_BEACONS; k++) begin
      run_start[k] = '0;
      run_stop[k]  = '0;
      run_len[k]   = '0;
      peak_len[k]  = '0;
      peak_mid[k]  = '0;
    end
  endfunction

  function automatic void close_run(int k);
    if (run_len[k] > peak_len[k]) begin
      peak_len[k] = run_len[k];
      peak_mid[k] = run_start[k] + (run_len[k] >> 1);
    end
  endfunction

  function automatic logic [15:0] fold_turn(logic [15:0] t);
    return (t > turn_ticks) ? t - turn_ticks : t;
  endfunction

  function automatic logic [15:0] scaled(logic [15:0] raw);
    longint p;
    p = longint'($signed(raw)) * longint'(angle_gain);
    p = p >>> ANGLE_SHIFT;
    return p[15:0];
  endfunction

  // advance the model by one request; return 1 when it yields a result
  function automatic bit absorb_request(input logic act, input logic [1:0] bc,
                                        input logic [15:0] ts, output angle_t res);
    int          d;
    logic [15:0] mo, co, mi, a, b;
    logic [1:0]  st;
    res = '0;
    if (act == ACT_EDGE) begin
      if (bc == BEACON_NONE) return 1'b0;
      d = int'(ts) - int'(run_stop[bc]);
      if (d < int'(gap_limit)) begin
        run_stop[bc] = ts;
        run_len[bc]  = ts - run_start[bc];
      end else begin
        close_run(bc);
        run_start[bc] = ts;
        run_stop[bc]  = ts;
        run_len[bc]   = '0;
      end
      return 1'b0;
    end
    for (int k = 0; k < NUM_BEACONS; k++) close_run(k);
    mo = peak_mid[BEACON_MOTHER];
    co = peak_mid[BEACON_CORNER];
    mi = peak_mid[BEACON_MIDDLE];
    a  = '0;
    b  = '0;
    st = STATUS_OK;
    if (mo < co && mo < mi) begin
      co = fold_turn(co - mo);
      mi = fold_turn(mi - mo);
      if (co < mi) st = STATUS_CORNER_MID;
      else begin
        a = turn_ticks - co;
        b = mi;
      end
    end else if (co < mo && co < mi) begin
      mo = fold_turn(mo - co);
      mi = fold_turn(mi - co);
      if (mi < mo) st = STATUS_MID_MOTHER;
      else begin
        a = mo;
        b = mi - mo;
      end
    end else begin
      // ties land here too
      mo = fold_turn(mo - mi);
      co = fold_turn(co - mi);
      if (mo < co) st = STATUS_MOTHER_COR;
      else begin
        a = mo - co;
        b = turn_ticks - mo;
      end
    end
    res.st = st;
    if (st == STATUS_OK) begin
      res.a = scaled(a);
      res.b = scaled(b);
    end
    clear_bursts();
    return 1'b1;
  endfunction

  task automatic send_request(input logic act, input logic [1:0] bc, input logic [15:0] ts,
                              input logic typed = 1'b0, input angle_t fixed = '0);
    angle_t res;
    int     gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_action    <= act;
    in_beacon    <= bc;
    in_timestamp <= ts;
    do @(posedge clk); while (!in_ready);
    if (absorb_request(act, bc, ts, res)) angles_due.push_back(typed ? fixed : res);
    if (!(act == ACT_EDGE && bc == BEACON_NONE)) sent++;
    if (run_left > 0) run_left--;
    else begin
      run_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold off until every result is back and edges still in flight are done
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] g, input logic [15:0] t,
                                input logic [15:0] s);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAP;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_index <= REG_TURN;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_index <= REG_SCALE;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we <= 1'b0;
    gap_limit  = g;
    turn_ticks = t;
    angle_gain = s;
  endtask

  // one rotation: a few bursts of close edges, then the compute request
  task automatic send_rotation();
    logic [15:0] t;
    logic [1:0]  bc;
    int          lim;
    t   = 16'($urandom_range(0, 3000));
    lim = (gap_limit > 16'd40) ? 40 : int'(gap_limit);
    repeat ($urandom_range(1, 6)) begin
      bc = ($urandom_range(0, 19) == 0) ? BEACON_NONE : 2'($urandom_range(0, 2));
      repeat ($urandom_range(1, 6)) begin
        send_request(ACT_EDGE, bc, t);
        t = 16'(t + $urandom_range(0, lim));
      end
      if ($urandom_range(0, 15) == 0) t = 16'(t - $urandom_range(1, 200));
      else t = 16'(t + $urandom_range(0, 600));
    end
    send_request(ACT_COMPUTE, 2'($urandom_range(0, 3)), 16'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_request(($urandom_range(0, 7) == 0) ? ACT_COMPUTE : ACT_EDGE,
                   2'($urandom_range(0, 3)), 16'($urandom));
  endtask

  always @(negedge clk) begin
    rx_phase <= rx_phase + 8'd1;
    case (rx_phase[7:6])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (rx_phase[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin : check_results
    angle_t want;
    if (rst_n && out_valid && out_ready) begin
      if (angles_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result with none pending: a=%0d b=%0d status=%0d",
                   out_angle_a, out_angle_b, out_status);
      end else begin
        want = angles_due.pop_front();
        if (out_angle_a !== want.a || out_angle_b !== want.b || out_status !== want.st) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: expected a=%0d b=%0d status=%0d, got a=%0d b=%0d status=%0d",
                     want.a, want.b, want.st, out_angle_a, out_angle_b, out_status);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] g, t, s;
    gap_limit  = GAP_RESET;
    turn_ticks = TURN_RESET;
    angle_gain = SCALE_RESET;
    clear_bursts();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(SCRIPT); i++)
      send_request(SCRIPT[i].act, SCRIPT[i].bc, SCRIPT[i].ts, SCRIPT[i].typed, SCRIPT[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin g = GAP_RESET; t = TURN_RESET; s = SCALE_RESET; end
        1: begin g = 16'd1; t = 16'd1; s = 16'hFFFF; end
        2: begin g = 16'hFFFF; t = 16'hFFFF; s = 16'd0; end
        3: begin
          g = 16'($urandom_range(1, 200));
          t = 16'($urandom_range(1, 65535));
          s = 16'($urandom);
        end
        4: begin g = 16'd100; t = 16'd4000; s = 16'd4096; end
        default: begin
          g = 16'($urandom_range(1, 65535));
          t = 16'($urandom_range(1, 65535));
          s = 16'($urandom);
        end
      endcase
      write_settings(g, t, s);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) send_rotation();
        else send_noise();
      end
    end

    quiesce();
    if (fault_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ibf_pkg.sv
rtl/core/ibf_front.sv
rtl/core/ibf_queue.sv
rtl/core/ibf_back.sv
rtl/core/ir_beacon_burst_angle_finder.sv
sim/tb.sv
